// File: rtl/differential_drive_odometry_assert.svh
// Assertion macros shared by the odometry RTL.
// Without SYNTHESIS they expand to concurrent assertions, otherwise to nothing.
`ifndef DIFFERENTIAL_DRIVE_ODOMETRY_ASSERT_SVH
`define DIFFERENTIAL_DRIVE_ODOMETRY_ASSERT_SVH

`ifndef SYNTHESIS

// Same-cycle implication.
`define DDO_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("odometry assertion failed");

// Next-cycle implication.
`define DDO_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("odometry assertion failed");

`else

`define DDO_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define DDO_ASSERT_NXT(lbl, clk, rstn, ante, cons)

`endif

`endif

// File: rtl/ddo_pkg.sv
package ddo_pkg;

  localparam int StepBits    = 24;
  localparam int CordicSteps = 16;
  localparam int SumBits     = StepBits + 1;
  localparam int IdxBits     = $clog2(CordicSteps);

  // Shared multiplier: signed A by signed B, one product per cycle.
  localparam int MulABits  = 34;
  localparam int MulBBits  = 17;
  localparam int ProdBits  = MulABits + MulBBits;
  localparam int AccBits   = 66;
  localparam int DeltaBits = 34;
  localparam int OutBits   = 192;

  localparam logic [31:0] GainQ30      = 32'd652032874;
  localparam logic [31:0] DistReset    = 32'd764222;
  localparam logic [31:0] TurnReset    = 32'd419420;
  localparam logic [9:0]  RateReset    = 10'd10;

  localparam logic [31:0] AtanTab [32] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
    32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
    32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163,
    32'd81, 32'd41, 32'd20, 32'd10, 32'd5, 32'd3, 32'd1, 32'd1, 32'd0
  };

  typedef enum logic [1:0] {
    CmdLeft,
    CmdRight,
    CmdTick
  } cmd_e;

  typedef enum logic [1:0] {
    RegDist,
    RegTurn,
    RegRate
  } reg_e;

  typedef enum logic [1:0] {
    Quad0,
    Quad90,
    Quad180,
    Quad270
  } quad_e;

  typedef enum logic [4:0] {
    StIdle,
    StTravLo,
    StTravHi,
    StTurnLo,
    StTurnHi,
    StTurnAdd,
    StAngle,
    StCordic,
    StTrig,
    StDxLo,
    StDxHi,
    StDyLo,
    StDyHi,
    StDyAdd,
    StVx,
    StVy,
    StLoad
  } state_e;

  typedef enum logic [2:0] {
    MulASum,
    MulADiff,
    MulATravel,
    MulADx,
    MulADy,
    MulADts
  } mula_e;

  typedef enum logic [3:0] {
    MulBDistLo,
    MulBDistHi,
    MulBTurnLo,
    MulBTurnHi,
    MulBCosLo,
    MulBCosHi,
    MulBSinLo,
    MulBSinHi,
    MulBRate
  } mulb_e;

  typedef enum logic [1:0] {
    AccHold,
    AccLoad,
    AccAddHi
  } acc_e;

  typedef struct packed {
    logic [31:0] dist_step;
    logic [31:0] turn;
    logic [9:0]  rate;
  } cfg_t;

  typedef struct packed {
    logic  step_left;
    logic  step_right;
    logic  tick_snap;
    logic  mul_en;
    mula_e mul_a;
    mulb_e mul_b;
    acc_e  acc_op;
    logic  travel_cap;
    logic  angle_start;
    logic  cordic_step;
    logic  trig_cap;
    logic  dx_cap;
    logic  dy_cap;
    logic  vx_cap;
    logic  vt_cap;
    logic  pose_x_upd;
    logic  pose_y_upd;
    logic  out_load;
  } ctl_t;

  typedef struct packed {
    logic cordic_last;
    logic out_free;
  } sts_t;

  function automatic logic signed [31:0] sat32(input logic signed [AccBits-1:0] v);
    logic all_zero;
    logic all_one;
    all_zero = ~|v[AccBits-1:31];
    all_one  = &v[AccBits-1:31];
    if (all_zero || all_one) begin
      return v[31:0];
    end
    return v[AccBits-1] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
  endfunction

  // Saturating add of a small signed step to a wheel count.
  function automatic logic signed [StepBits-1:0] step_add(
    input logic signed [StepBits-1:0] cnt,
    input logic signed [1:0]          way
  );
    logic signed [SumBits-1:0] v;
    logic signed [SumBits-1:0] hi;
    logic signed [SumBits-1:0] lo;
    hi = SumBits'({1'b0, {(StepBits-1){1'b1}}});
    lo = -hi - SumBits'(1);
    v  = SumBits'(cnt) + SumBits'(way);
    if (v > hi) begin
      return hi[StepBits-1:0];
    end
    if (v < lo) begin
      return lo[StepBits-1:0];
    end
    return v[StepBits-1:0];
  endfunction

endpackage

// File: rtl/ddo_ctrl.sv
module ddo_ctrl import ddo_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic [1:0] in_cmd_i,
  output logic       in_ready_o,
  input  sts_t       sts_i,
  output ctl_t       ctl_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    ctl_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          case (in_cmd_i)
            CmdLeft:  ctl_o.step_left  = 1'b1;
            CmdRight: ctl_o.step_right = 1'b1;
            CmdTick: begin
              ctl_o.tick_snap = 1'b1;
              state_d         = StTravLo;
            end
            default: ;
          endcase
        end
      end
      StTravLo: begin
        ctl_o.mul_en = 1'b1;
        ctl_o.mul_a  = MulASum;
        ctl_o.mul_b  = MulBDistLo;
        state_d      = StTravHi;
      end
      StTravHi: begin
        ctl_o.acc_op = AccLoad;
        ctl_o.mul_en = 1'b1;
        ctl_o.mul_a  = MulASum;
        ctl_o.mul_b  = MulBDistHi;
        state_d      = StTurnLo;
      end
      StTurnLo: begin
        ctl_o.acc_op = AccAddHi;
        ctl_o.mul_en = 1'b1;
        ctl_o.mul_a  = MulADiff;
        ctl_o.mul_b  = MulBTurnLo;
        state_d      = StTurnHi;
      end
      StTurnHi: begin
        ctl_o.travel_cap = 1'b1;
        ctl_o.acc_op     = AccLoad;
        ctl_o.mul_en     = 1'b1;
        ctl_o.mul_a      = MulADiff;
        ctl_o.mul_b      = MulBTurnHi;
        state_d          = StTurnAdd;
      end
      StTurnAdd: begin
        ctl_o.acc_op = AccAddHi;
        state_d      = StAngle;
      end
      StAngle: begin
        ctl_o.angle_start = 1'b1;
        state_d           = StCordic;
      end
      StCordic: begin
        ctl_o.cordic_step = 1'b1;
        if (sts_i.cordic_last) begin
          state_d = StTrig;
        end
      end
      StTrig: begin
        ctl_o.trig_cap = 1'b1;
        state_d        = StDxLo;
      end
      StDxLo: begin
        ctl_o.mul_en = 1'b1;
        ctl_o.mul_a  = MulATravel;
        ctl_o.mul_b  = MulBCosLo;
        state_d      = StDxHi;
      end
      StDxHi: begin
        ctl_o.acc_op = AccLoad;
        ctl_o.mul_en = 1'b1;
        ctl_o.mul_a  = MulATravel;
        ctl_o.mul_b  = MulBCosHi;
        state_d      = StDyLo;
      end
      StDyLo: begin
        ctl_o.acc_op = AccAddHi;
        ctl_o.mul_en = 1'b1;
        ctl_o.mul_a  = MulATravel;
        ctl_o.mul_b  = MulBSinLo;
        state_d      = StDyHi;
      end
      StDyHi: begin
        ctl_o.dx_cap = 1'b1;
        ctl_o.acc_op = AccLoad;
        ctl_o.mul_en = 1'b1;
        ctl_o.mul_a  = MulATravel;
        ctl_o.mul_b  = MulBSinHi;
        state_d      = StDyAdd;
      end
      StDyAdd: begin
        ctl_o.acc_op = AccAddHi;
        ctl_o.mul_en = 1'b1;
        ctl_o.mul_a  = MulADx;
        ctl_o.mul_b  = MulBRate;
        state_d      = StVx;
      end
      StVx: begin
        ctl_o.dy_cap     = 1'b1;
        ctl_o.vx_cap     = 1'b1;
        ctl_o.pose_x_upd = 1'b1;
        ctl_o.mul_en     = 1'b1;
        ctl_o.mul_a      = MulADts;
        ctl_o.mul_b      = MulBRate;
        state_d          = StVy;
      end
      StVy: begin
        ctl_o.vt_cap     = 1'b1;
        ctl_o.pose_y_upd = 1'b1;
        ctl_o.mul_en     = 1'b1;
        ctl_o.mul_a      = MulADy;
        ctl_o.mul_b      = MulBRate;
        state_d          = StLoad;
      end
      StLoad: begin
        // The product register holds the last speed until the output frees up.
        if (sts_i.out_free) begin
          ctl_o.out_load = 1'b1;
          state_d        = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

endmodule

// File: rtl/ddo_datapath.sv
module ddo_datapath import ddo_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ctl_t                ctl_i,
  output sts_t                sts_o,
  input  cfg_t                cfg_i,
  input  logic signed [1:0]   way_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [OutBits-1:0]  out_data_o
);

  logic signed [StepBits-1:0]  left_q, left_d;
  logic signed [StepBits-1:0]  right_q, right_d;
  logic signed [SumBits-1:0]   sum_q, diff_q;
  logic signed [MulABits-1:0]  mul_a;
  logic signed [MulBBits-1:0]  mul_b;
  logic signed [ProdBits-1:0]  prod_q;
  logic signed [AccBits-1:0]   acc_q, acc_d;
  logic signed [AccBits-1:0]   prod_ext;
  logic signed [31:0]          travel_q;
  logic [31:0]                 dth_q;
  logic [31:0]                 mid;
  logic signed [31:0]          x_q, y_q, z_q;
  logic signed [31:0]          atan;
  quad_e                       quad_q;
  logic [IdxBits-1:0]          cnt_q;
  logic signed [31:0]          cos_d, sin_d, cos_q, sin_q;
  logic signed [DeltaBits-1:0] dx_q, dy_q;
  logic signed [31:0]          vx_q, vt_q, v_now;
  logic signed [31:0]          pose_x_q, pose_y_q;
  logic [31:0]                 head_q;
  logic                        out_valid_q;
  logic [OutBits-1:0]          out_data_q;

  // Wheel step counters.
  always_comb begin
    left_d  = left_q;
    right_d = right_q;
    if (ctl_i.tick_snap) begin
      left_d  = '0;
      right_d = '0;
    end else begin
      if (ctl_i.step_left) begin
        left_d = step_add(left_q, way_i);
      end
      if (ctl_i.step_right) begin
        right_d = step_add(right_q, way_i);
      end
    end
  end

  // Operand selection for the shared multiplier.
  always_comb begin
    case (ctl_i.mul_a)
      MulASum:    mul_a = MulABits'(sum_q);
      MulADiff:   mul_a = MulABits'(diff_q);
      MulATravel: mul_a = MulABits'(travel_q);
      MulADx:     mul_a = MulABits'(dx_q);
      MulADy:     mul_a = MulABits'(dy_q);
      MulADts:    mul_a = MulABits'($signed(dth_q));
      default:    mul_a = '0;
    endcase
    case (ctl_i.mul_b)
      MulBDistLo: mul_b = $signed(MulBBits'(cfg_i.dist_step[15:0]));
      MulBDistHi: mul_b = $signed(MulBBits'(cfg_i.dist_step[31:16]));
      MulBTurnLo: mul_b = $signed(MulBBits'(cfg_i.turn[15:0]));
      MulBTurnHi: mul_b = $signed(MulBBits'(cfg_i.turn[31:16]));
      MulBCosLo:  mul_b = $signed(MulBBits'(cos_q[15:0]));
      MulBCosHi:  mul_b = MulBBits'($signed(cos_q[31:16]));
      MulBSinLo:  mul_b = $signed(MulBBits'(sin_q[15:0]));
      MulBSinHi:  mul_b = MulBBits'($signed(sin_q[31:16]));
      MulBRate:   mul_b = $signed(MulBBits'(cfg_i.rate));
      default:    mul_b = '0;
    endcase
  end

  // Wide products are built as low half plus high half shifted by 16.
  assign prod_ext = AccBits'(prod_q);

  always_comb begin
    case (ctl_i.acc_op)
      AccLoad:  acc_d = prod_ext;
      AccAddHi: acc_d = acc_q + (prod_ext <<< 16);
      default:  acc_d = acc_q;
    endcase
  end

  assign v_now = sat32(prod_ext);

  // The mid-step heading is the old heading plus half the turn.
  assign mid  = head_q + {acc_q[31], acc_q[31:1]};
  assign atan = $signed(AtanTab[5'(cnt_q)]);

  always_comb begin
    case (quad_q)
      Quad0: begin
        cos_d = x_q;
        sin_d = y_q;
      end
      Quad90: begin
        cos_d = -y_q;
        sin_d = x_q;
      end
      Quad180: begin
        cos_d = -x_q;
        sin_d = -y_q;
      end
      default: begin
        cos_d = y_q;
        sin_d = -x_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q      <= '0;
      right_q     <= '0;
      pose_x_q    <= '0;
      pose_y_q    <= '0;
      head_q      <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      left_q  <= left_d;
      right_q <= right_d;
      if (ctl_i.pose_x_upd) begin
        pose_x_q <= sat32(AccBits'(pose_x_q) + AccBits'(dx_q));
      end
      if (ctl_i.pose_y_upd) begin
        pose_y_q <= sat32(AccBits'(pose_y_q) + AccBits'(dy_q));
        head_q   <= head_q + dth_q;
      end
      if (ctl_i.angle_start) begin
        cnt_q <= '0;
      end else if (ctl_i.cordic_step) begin
        cnt_q <= cnt_q + IdxBits'(1);
      end
      if (ctl_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.tick_snap) begin
      sum_q  <= SumBits'(left_q) + SumBits'(right_q);
      diff_q <= SumBits'(right_q) - SumBits'(left_q);
    end
    if (ctl_i.mul_en) begin
      prod_q <= mul_a * mul_b;
    end
    acc_q <= acc_d;
    if (ctl_i.travel_cap) begin
      travel_q <= sat32(acc_q >>> 17);
    end
    if (ctl_i.angle_start) begin
      dth_q  <= acc_q[31:0];
      quad_q <= quad_e'(mid[31:30]);
      x_q    <= $signed(GainQ30);
      y_q    <= '0;
      z_q    <= $signed({2'b00, mid[29:0]});
    end else if (ctl_i.cordic_step) begin
      if (!z_q[31]) begin
        x_q <= x_q - (y_q >>> cnt_q);
        y_q <= y_q + (x_q >>> cnt_q);
        z_q <= z_q - atan;
      end else begin
        x_q <= x_q + (y_q >>> cnt_q);
        y_q <= y_q - (x_q >>> cnt_q);
        z_q <= z_q + atan;
      end
    end
    if (ctl_i.trig_cap) begin
      cos_q <= cos_d;
      sin_q <= sin_d;
    end
    if (ctl_i.dx_cap) begin
      dx_q <= $signed(acc_q[63:30]);
    end
    if (ctl_i.dy_cap) begin
      dy_q <= $signed(acc_q[63:30]);
    end
    if (ctl_i.vx_cap) begin
      vx_q <= v_now;
    end
    if (ctl_i.vt_cap) begin
      vt_q <= v_now;
    end
    if (ctl_i.out_load) begin
      out_data_q <= {vt_q, v_now, vx_q, head_q, pose_y_q, pose_x_q};
    end
  end

  assign sts_o.cordic_last = (cnt_q == IdxBits'(CordicSteps - 1));
  assign sts_o.out_free    = !out_valid_q || out_ready_i;
  assign out_valid_o       = out_valid_q;
  assign out_data_o        = out_data_q;

endmodule

// File: rtl/differential_drive_odometry.sv
// Dead-reckoning odometry for a two-wheel robot.
// Input stream: tuser carries the command (left step, right step, sample tick),
// tdata carries the signed step direction. A wheel step keeps the controller
// idle and the input stays ready. A sample tick snapshots and clears both
// wheel counts and starts a pose update; the input is held off until it
// finishes. A tick forms the travel and turn products on the shared 34x17
// multiplier, runs one CORDIC rotation per cycle, then forms the position and
// speed products through the same multiplier. The result sits in an output
// register; when the receiver stalls it holds its value and the block waits
// only if a second tick completes meanwhile. Configuration sits on the APB
// port (dist_per_step at 0x0, turn_per_step_diff at 0x4, tick_rate at 0x8);
// the user must write it only while the block is idle; nothing enforces it.
// Reset clears the wheel counts and the pose and restores register defaults.
`include "differential_drive_odometry_assert.svh"

module differential_drive_odometry import ddo_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // tdata: [1:0] way, rest zero.
  input  logic [7:0]          s_axis_tdata,
  // tuser: [1:0] cmd.
  input  logic [1:0]          s_axis_tuser,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // tdata: [31:0] x_pos, [63:32] y_pos, [95:64] heading, [127:96] x_speed,
  // [159:128] y_speed, [191:160] turn_speed.
  output logic [OutBits-1:0]  m_axis_tdata,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [3:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  cfg_t cfg_q;
  ctl_t ctl;
  sts_t sts;
  logic in_txn;
  logic tick_txn;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.dist_step <= DistReset;
      cfg_q.turn      <= TurnReset;
      cfg_q.rate      <= RateReset;
    end else if (psel && penable && pwrite) begin
      unique case (reg_e'(paddr[3:2]))
        RegDist: cfg_q.dist_step <= pwdata;
        RegTurn: cfg_q.turn      <= pwdata;
        RegRate: cfg_q.rate      <= pwdata[9:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_e'(paddr[3:2]))
      RegDist: prdata = cfg_q.dist_step;
      RegTurn: prdata = cfg_q.turn;
      RegRate: prdata = 32'(cfg_q.rate);
      default: prdata = '0;
    endcase
  end

  assign pready = 1'b1;

  ddo_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_cmd_i   (s_axis_tuser),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .ctl_o      (ctl)
  );

  ddo_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctl_i       (ctl),
    .sts_o       (sts),
    .cfg_i       (cfg_q),
    .way_i       ($signed(s_axis_tdata[1:0])),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata)
  );

  assign in_txn   = s_axis_tvalid && s_axis_tready;
  assign tick_txn = in_txn && (s_axis_tuser == CmdTick);

  // A tick transaction starts an update, so the input must close next cycle.
  `DDO_ASSERT_NXT(a_tick_closes_input, clk_i, rst_ni, tick_txn, !s_axis_tready)
  // Step and unused commands never leave the idle state.
  `DDO_ASSERT_NXT(a_step_keeps_ready, clk_i, rst_ni, in_txn && !tick_txn, s_axis_tready)
  // A new result is loaded only into a free output register.
  `DDO_ASSERT_IMP(a_load_when_free, clk_i, rst_ni, ctl.out_load, !m_axis_tvalid || m_axis_tready)

endmodule
